// ===== rtl/core/ptfr_pkg.sv =====
// Shared types, opcodes and the 5x7 font for the page frame buffer text renderer.
// No dependencies; the top level, front, back and testbench refer to it by scoped names.
package ptfr_pkg;

  // Input operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_CHAR    = 2'd1;
  localparam logic [1:0] OP_NUMBER  = 2'd2;
  localparam logic [1:0] OP_REFRESH = 2'd3;

  // Command kinds carried from front to back
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_CHAR    = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  localparam int GLYPH_W = 5;
  localparam int PITCH   = 6;
  localparam int POS_W   = 9;   // column position incl. digit pitch overrun
  localparam int PAGE_W  = 3;
  localparam int GIDX_W  = 6;
  localparam int MAXPG   = 8;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> 35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [1:0]        kind;
    logic [POS_W-1:0]  col;
    logic [PAGE_W-1:0] page;
    logic [GIDX_W-1:0] glyph;
  } cmd_t;

  // Glyph columns, lowest byte is the leftmost column
  localparam logic [39:0] FONT [0:38] = '{
    40'h0000000000, 40'h3E4549513E, 40'h00407F4200, 40'h4649516142,
    40'h314B454121, 40'h107F121418, 40'h3945454527, 40'h3049494A3C,
    40'h0305097101, 40'h3649494936, 40'h1E29494906, 40'h0808080808,
    40'h0000363600, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h4345495161
  };

  // ASCII to glyph index; anything outside the set maps to space
  function automatic logic [GIDX_W-1:0] glyph_of(input logic [7:0] code);
    logic [GIDX_W-1:0] g;
    g = '0;
    if (code >= 8'h30 && code <= 8'h39) g = GIDX_W'(code - 8'h30 + 8'd1);
    else if (code == 8'h2D) g = GIDX_W'(11);
    else if (code == 8'h3A) g = GIDX_W'(12);
    else if (code >= 8'h41 && code <= 8'h5A) g = GIDX_W'(code - 8'h41 + 8'd13);
    return g;
  endfunction

endpackage

// ===== rtl/core/ptfr_cmd_if.sv =====
// Input item channel: operation and drawing arguments with valid/ready.
// Standalone; no package use.
interface ptfr_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [6:0]        column;
  logic [2:0]        page;
  logic [7:0]        character;
  logic signed [31:0] number_value;
  logic [7:0]        digit_count;

  modport source (output valid, operation, column, page, character, number_value,
                  digit_count, input ready);
  modport sink (input valid, operation, column, page, character, number_value,
                digit_count, output ready);
endinterface

// ===== rtl/core/ptfr_chunk_if.sv =====
// Result channel: one 32-column chunk of a page per transfer.
// Standalone; no package use.
interface ptfr_chunk_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_page;
  logic [1:0]  chunk;
  logic [6:0]  start_column;
  logic        first_of_page;
  logic [63:0] bytes_a;
  logic [63:0] bytes_b;
  logic [63:0] bytes_c;
  logic [63:0] bytes_d;
  logic        last;

  modport source (output valid, out_page, chunk, start_column, first_of_page,
                  bytes_a, bytes_b, bytes_c, bytes_d, last, input ready);
  modport sink (input valid, out_page, chunk, start_column, first_of_page,
                bytes_a, bytes_b, bytes_c, bytes_d, last, output ready);
endinterface

// ===== rtl/core/ptfr_cfg_if.sv =====
// Configuration write channel: column offset register data with valid/ready.
// Standalone; no package use.
interface ptfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/page_framebuffer_text_renderer.sv =====
// Top level of the page frame buffer text renderer: front, command queue, back.
// Uses ptfr_pkg, ptfr_front, ptfr_fifo, ptfr_back and the three channel interfaces.
//
//  channel | dir | payload                                       | transfer when
//  in_if   | in  | operation, column, page, character, number... | valid && ready
//  out_if  | out | out_page, chunk, start_column, bytes_a..d...  | valid && ready
//  cfg_if  | in  | column offset (4 bits)                        | valid && ready
//
// Draw character: the back pops it, then reads and rewrites a row per glyph column.
// Draw number: per digit, front reciprocal multiply then remainder; back draws each.
// Refresh: scan each page; per chunk of a dirty page, four row reads plus output.
// Reset: row valid bits clear the store at once; no clearing pass.
// The four-entry queue lets the front accept while the back writes or waits on out_if.
module page_framebuffer_text_renderer #(
  parameter int COLUMNS    = 128,
  parameter int PAGES      = 8,
  parameter int MAX_DIGITS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  ptfr_cmd_if.sink     in_if,
  ptfr_chunk_if.source out_if,
  ptfr_cfg_if.sink     cfg_if
);
  localparam int CMD_W = $bits(ptfr_pkg::cmd_t);

  logic           push, q_full, pop, q_valid;
  ptfr_pkg::cmd_t push_data, q_data;

  ptfr_front #(.PAGES(PAGES), .MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  ptfr_fifo #(.W(CMD_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  ptfr_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_data),
    .cmd_pop   (pop),
    .out_if    (out_if),
    .cfg_if    (cfg_if)
  );
endmodule

// ===== rtl/core/ptfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/ptfr_fifo.sv =====
// Four-entry command queue between the front and back parts.
// No package dependency; width set by the instantiating module.
module ptfr_fifo #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] mem_r [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;

  assign full      = (cnt_r == 3'd4);
  assign pop_valid = (cnt_r != 3'd0);
  assign pop_data  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end
endmodule

// ===== rtl/core/ptfr_front.sv =====
// Front part: accepts input items, maps characters, splits numbers into digits.
// Uses ptfr_pkg and ptfr_cmd_if; pushes ptfr_pkg::cmd_t into the queue.
module ptfr_front #(
  parameter int PAGES      = 8,
  parameter int MAX_DIGITS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  ptfr_cmd_if.sink          in_if,
  output logic              push,
  output ptfr_pkg::cmd_t    push_data,
  input  logic              q_full
);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_REM  = 2'd2;

  logic [1:0]  fs_r, fs_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [28:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [ptfr_pkg::POS_W-1:0] col_r, col_nxt;
  logic [2:0]  page_r, page_nxt;

  logic        acc;
  logic [7:0]  cnt_clamp;
  logic [31:0] raw;
  logic [3:0]  rem;
  logic [63:0] prod;

  assign acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (fs_r == F_IDLE) && !q_full;
  assign raw      = in_if.number_value;
  assign cnt_clamp = (in_if.digit_count > 8'(MAX_DIGITS)) ? 8'(MAX_DIGITS)
                                                          : in_if.digit_count;
  assign prod     = mag_r * ptfr_pkg::RECIP10;
  assign rem      = 4'(mag_r - {q_r, 3'b000} - {q_r, 1'b0});

  // next state and queue push
  always_comb begin
    fs_nxt    = fs_r;
    mag_nxt   = mag_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    page_nxt  = page_r;
    push      = 1'b0;
    push_data = '0;
    unique case (fs_r)
      F_IDLE: begin
        if (acc) begin
          unique case (in_if.operation)
            ptfr_pkg::OP_CLEAR: begin
              push           = 1'b1;
              push_data.kind = ptfr_pkg::CMD_CLEAR;
            end
            ptfr_pkg::OP_CHAR: begin
              push            = (int'(in_if.page) < PAGES);
              push_data.kind  = ptfr_pkg::CMD_CHAR;
              push_data.col   = ptfr_pkg::POS_W'(in_if.column);
              push_data.page  = in_if.page;
              push_data.glyph = ptfr_pkg::glyph_of(in_if.character);
            end
            ptfr_pkg::OP_NUMBER: begin
              if ((int'(in_if.page) < PAGES) && (cnt_clamp != 8'd0)) begin
                fs_nxt   = F_MUL;
                mag_nxt  = raw[31] ? (32'd0 - raw) : raw;
                cnt_nxt  = CW'(cnt_clamp);
                col_nxt  = ptfr_pkg::POS_W'(int'(in_if.column)
                           + ptfr_pkg::PITCH * (int'(cnt_clamp) - 1));
                page_nxt = in_if.page;
              end
            end
            ptfr_pkg::OP_REFRESH: begin
              push           = 1'b1;
              push_data.kind = ptfr_pkg::CMD_REFRESH;
            end
            default: ;
          endcase
        end
      end
      F_MUL: begin
        q_nxt  = prod[63:35];
        fs_nxt = F_REM;
      end
      F_REM: begin
        // lowest remaining digit goes to the rightmost remaining cell
        if (!q_full) begin
          push            = 1'b1;
          push_data.kind  = ptfr_pkg::CMD_CHAR;
          push_data.col   = col_r;
          push_data.page  = page_r;
          push_data.glyph = ptfr_pkg::GIDX_W'(rem) + ptfr_pkg::GIDX_W'(1);
          mag_nxt = 32'(q_r);
          col_nxt = col_r - ptfr_pkg::POS_W'(ptfr_pkg::PITCH);
          cnt_nxt = cnt_r - CW'(1);
          fs_nxt  = (cnt_r == CW'(1)) ? F_IDLE : F_MUL;
        end
      end
      default: fs_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= F_IDLE;
    end else begin
      fs_r <= fs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    col_r  <= col_nxt;
    page_r <= page_nxt;
  end
endmodule

// ===== rtl/core/ptfr_back.sv =====
// Back part: frame store, dirty mask, glyph writes and page refresh output.
// Uses ptfr_pkg, ptfr_ram, ptfr_chunk_if and ptfr_cfg_if.
module ptfr_back #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  ptfr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  ptfr_chunk_if.source   out_if,
  ptfr_cfg_if.sink       cfg_if
);
  localparam int RPP   = (COLUMNS + 7) / 8;   // 8-column rows per page
  localparam int DEPTH = PAGES * RPP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CRD  = 3'd1;
  localparam logic [2:0] B_CWR  = 3'd2;
  localparam logic [2:0] B_SCAN = 3'd3;
  localparam logic [2:0] B_RRD  = 3'd4;
  localparam logic [2:0] B_RCAP = 3'd5;
  localparam logic [2:0] B_ROUT = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [ptfr_pkg::POS_W-1:0]  col_r, col_nxt;
  logic [2:0]  page_r, page_nxt;
  logic [ptfr_pkg::GIDX_W-1:0] glyph_r, glyph_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  p_r, p_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [1:0]  j_r, j_nxt;
  logic [63:0] buf_r [4];
  logic [7:0]  dirty_r, dirty_nxt;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic        rd_vld_r, rd_zero_r, rd_zero_nxt;
  logic [3:0]  coff_r;

  logic        out_valid_r;
  logic [2:0]  o_page_r;
  logic [1:0]  o_chunk_r;
  logic [6:0]  o_start_r;
  logic        o_first_r, o_last_r;
  logic [63:0] o_a_r, o_b_r, o_c_r, o_d_r;
  logic        o_load;

  logic [AW-1:0] raddr, waddr;
  logic [63:0]   rdata, wdata, cur_row;
  logic          we;
  logic [ptfr_pkg::POS_W-1:0] cpos;
  logic [3:0]    rin;
  logic [39:0]   gbits;
  logic [2:0]    pg;

  function automatic logic [AW-1:0] row_of(input logic [2:0] p, input logic [5:0] r);
    return AW'(int'(p) * RPP + int'(r));
  endfunction

  ptfr_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cpos    = col_r + ptfr_pkg::POS_W'(idx_r);
  assign rin     = {k_r, j_r};
  assign pg      = p_r[2:0];
  assign gbits   = ptfr_pkg::FONT[glyph_r];
  assign cur_row = rd_vld_r ? rdata : 64'd0;
  assign o_load  = (st_r == B_ROUT) && (!out_valid_r || out_if.ready);
  assign cfg_if.ready = 1'b1;

  // sequencer
  always_comb begin
    st_nxt      = st_r;
    col_nxt     = col_r;
    page_nxt    = page_r;
    glyph_nxt   = glyph_r;
    idx_nxt     = idx_r;
    p_nxt       = p_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    dirty_nxt   = dirty_r;
    vld_nxt     = vld_r;
    rd_zero_nxt = 1'b0;
    cmd_pop     = 1'b0;
    raddr       = '0;
    waddr       = row_of(page_r, cpos[8:3]);
    we          = 1'b0;
    wdata       = cur_row;
    wdata[8*cpos[2:0] +: 8] = gbits[8*idx_r +: 8];
    unique case (st_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            ptfr_pkg::CMD_CLEAR: begin
              vld_nxt   = '0;
              dirty_nxt = 8'((9'd1 << PAGES) - 9'd1);
            end
            ptfr_pkg::CMD_CHAR: begin
              // cell must fit with its gap column
              if (int'(cmd.col) + ptfr_pkg::PITCH <= COLUMNS) begin
                col_nxt   = cmd.col;
                page_nxt  = cmd.page;
                glyph_nxt = cmd.glyph;
                idx_nxt   = '0;
                st_nxt    = B_CRD;
              end
            end
            ptfr_pkg::CMD_REFRESH: begin
              p_nxt  = '0;
              st_nxt = B_SCAN;
            end
            default: ;
          endcase
        end
      end
      B_CRD: begin
        raddr  = row_of(page_r, cpos[8:3]);
        st_nxt = B_CWR;
      end
      B_CWR: begin
        we = 1'b1;
        vld_nxt[waddr] = 1'b1;
        if (idx_r == 3'(ptfr_pkg::GLYPH_W - 1)) begin
          dirty_nxt[page_r] = 1'b1;
          st_nxt = B_IDLE;
        end else begin
          idx_nxt = idx_r + 3'd1;
          st_nxt  = B_CRD;
        end
      end
      B_SCAN: begin
        if (int'(p_r) >= PAGES) begin
          st_nxt = B_IDLE;
        end else if (dirty_r[pg]) begin
          k_nxt  = '0;
          j_nxt  = '0;
          st_nxt = B_RRD;
        end else begin
          p_nxt = p_r + 4'd1;
        end
      end
      B_RRD: begin
        if (int'(rin) < RPP) begin
          raddr = row_of(pg, 6'(rin));
        end else begin
          rd_zero_nxt = 1'b1;
        end
        st_nxt = B_RCAP;
      end
      B_RCAP: begin
        if (j_r == 2'd3) begin
          st_nxt = B_ROUT;
        end else begin
          j_nxt  = j_r + 2'd1;
          st_nxt = B_RRD;
        end
      end
      B_ROUT: begin
        if (o_load) begin
          if (k_r == 2'd3) begin
            dirty_nxt[pg] = 1'b0;
            p_nxt  = p_r + 4'd1;
            st_nxt = B_SCAN;
          end else begin
            k_nxt  = k_r + 2'd1;
            j_nxt  = '0;
            st_nxt = B_RRD;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      dirty_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      coff_r      <= 4'd2;
    end else begin
      st_r    <= st_nxt;
      dirty_r <= dirty_nxt;
      vld_r   <= vld_nxt;
      if (o_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        coff_r <= cfg_if.data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    page_r    <= page_nxt;
    glyph_r   <= glyph_nxt;
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    rd_vld_r  <= vld_r[raddr];
    rd_zero_r <= rd_zero_nxt;
    if (st_r == B_RCAP) begin
      buf_r[j_r] <= rd_zero_r ? 64'd0 : cur_row;
    end
    if (o_load) begin
      o_page_r  <= pg;
      o_chunk_r <= k_r;
      o_start_r <= 7'(coff_r) + {k_r, 5'b00000};
      o_first_r <= (k_r == 2'd0);
      o_last_r  <= (k_r == 2'd3) && ((dirty_r & ~(8'd1 << pg)) == 8'd0);
      o_a_r     <= buf_r[0];
      o_b_r     <= buf_r[1];
      o_c_r     <= buf_r[2];
      o_d_r     <= buf_r[3];
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_page      = o_page_r;
  assign out_if.chunk         = o_chunk_r;
  assign out_if.start_column  = o_start_r;
  assign out_if.first_of_page = o_first_r;
  assign out_if.bytes_a       = o_a_r;
  assign out_if.bytes_b       = o_b_r;
  assign out_if.bytes_c       = o_c_r;
  assign out_if.bytes_d       = o_d_r;
  assign out_if.last          = o_last_r;
endmodule

// ===== verif/page_framebuffer_text_renderer_tb.sv =====
// Testbench for page_framebuffer_text_renderer: directed table, then random draws and refreshes.
// Depends on ptfr_pkg, the three channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module page_framebuffer_text_renderer_tb;

  localparam logic [1:0] OP_CLEAR   = ptfr_pkg::OP_CLEAR;
  localparam logic [1:0] OP_CHAR    = ptfr_pkg::OP_CHAR;
  localparam logic [1:0] OP_NUMBER  = ptfr_pkg::OP_NUMBER;
  localparam logic [1:0] OP_REFRESH = ptfr_pkg::OP_REFRESH;
  localparam int PITCH   = ptfr_pkg::PITCH;
  localparam int GLYPH_W = ptfr_pkg::GLYPH_W;

  localparam int NCOL = 128;
  localparam int NPAGE = 8;
  localparam int NDIG = 7;
  localparam int SETTLE = 500;      // covers a full command queue of seven-digit numbers
  localparam int WATCHDOG = 5000;
  localparam string GLYPH_SET = " 0123456789-:ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  col;
    logic [2:0]  page;
    logic [7:0]  ch;
    logic [31:0] num;
    logic [7:0]  cnt;
    logic        glance;      // expected chunks typed in: blank pages from pg_mask
    logic [7:0]  pg_mask;
  } draw_item_t;

  typedef struct packed {
    logic [2:0]  page;
    logic [1:0]  chunk;
    logic [6:0]  start;
    logic        first;
    logic [63:0] a, b, c, d;
    logic        last;
  } chunk_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptfr_cmd_if   in_if();
  ptfr_chunk_if out_if();
  ptfr_cfg_if   cfg_if();

  page_framebuffer_text_renderer u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow of the frame store and settings
  logic [7:0] fb [NPAGE][NCOL];
  logic [7:0] dirty;
  logic [3:0] col_ofs;
  chunk_t     chunk_q[$];
  draw_item_t dir_rows[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_chunks = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;

  initial begin
    in_if.valid = 1'b0; in_if.operation = OP_CLEAR; in_if.column = '0; in_if.page = '0;
    in_if.character = '0; in_if.number_value = '0; in_if.digit_count = '0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic int glyph_index(logic [7:0] code);
    if (code >= "0" && code <= "9") return 1 + int'(code - "0");
    if (code == "-") return 11;
    if (code == ":") return 12;
    if (code >= "A" && code <= "Z") return 13 + int'(code - "A");
    return 0;
  endfunction

  function automatic bit put_glyph(int col, int page, logic [7:0] code);
    int g;
    if (col + PITCH > NCOL) return 1'b0;
    g = glyph_index(code);
    for (int i = 0; i < GLYPH_W; i++) fb[page][col + i] = ptfr_pkg::FONT[g][8*i +: 8];
    dirty[page] = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [63:0] row_bytes(int page, int first);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = fb[page][first + i];
    return v;
  endfunction

  // Update the shadow store; queue the chunks a refresh sends
  function automatic void predict_draw(draw_item_t it, bit queue_chunks);
    logic [31:0] mag;
    logic [7:0] digs [NDIG];
    int n;
    chunk_t ck;
    case (it.op)
      OP_CLEAR: begin
        for (int p = 0; p < NPAGE; p++)
          for (int c = 0; c < NCOL; c++) fb[p][c] = '0;
        dirty = '1;
      end
      OP_CHAR: void'(put_glyph(it.col, it.page, it.ch));
      OP_NUMBER: begin
        mag = it.num[31] ? -it.num : it.num;
        n = (it.cnt > NDIG) ? NDIG : it.cnt;
        for (int i = n; i > 0; i--) begin
          digs[i-1] = 8'("0" + mag % 10);
          mag = mag / 10;
        end
        for (int i = 0; i < n; i++)
          if (!put_glyph(it.col + PITCH * i, it.page, digs[i])) break;
      end
      default: begin
        n = 0;
        for (int p = 0; p < NPAGE; p++) begin
          if (dirty[p]) begin
            for (int k = 0; k < 4; k++) begin
              ck.page = 3'(p); ck.chunk = 2'(k);
              ck.start = 7'(col_ofs + 32 * k);
              ck.first = (k == 0);
              ck.a = row_bytes(p, 32*k);      ck.b = row_bytes(p, 32*k + 8);
              ck.c = row_bytes(p, 32*k + 16); ck.d = row_bytes(p, 32*k + 24);
              ck.last = 1'b0;
              if (queue_chunks) chunk_q.push_back(ck);
              n++;
            end
          end
        end
        dirty = '0;
        if (queue_chunks && n > 0) chunk_q[$].last = 1'b1;
      end
    endcase
  endfunction

  // Typed-in expectation: the masked pages sent blank
  function automatic void queue_blank_pages(logic [7:0] mask);
    chunk_t ck;
    int n;
    n = 0;
    for (int p = 0; p < NPAGE; p++) begin
      if (mask[p]) begin
        for (int k = 0; k < 4; k++) begin
          ck = '{page: 3'(p), chunk: 2'(k), start: 7'(col_ofs + 32 * k), first: (k == 0),
                 a: '0, b: '0, c: '0, d: '0, last: 1'b0};
          chunk_q.push_back(ck);
          n++;
        end
      end
    end
    if (n > 0) chunk_q[$].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(draw_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;       in_if.operation <= it.op;
    in_if.column <= it.col;    in_if.page <= it.page;
    in_if.character <= it.ch;  in_if.number_value <= it.num;
    in_if.digit_count <= it.cnt;
    do @(posedge clk); while (!in_if.ready);
    // transfer taken: update shadow
    if (it.glance) begin
      predict_draw(it, 1'b0);
      queue_blank_pages(it.pg_mask);
    end else begin
      predict_draw(it, 1'b1);
    end
    n_items++;
  endtask

  task automatic wait_drained();
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_offset(logic [3:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1; cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    col_ofs = v;
    @(negedge clk) cfg_if.valid <= 1'b0;
  endtask

  function automatic draw_item_t rand_item();
    draw_item_t it;
    int r;
    it = '0;
    r = $urandom_range(0, 99);
    it.op = (r < 3) ? OP_CLEAR : (r < 45) ? OP_CHAR : (r < 82) ? OP_NUMBER : OP_REFRESH;
    it.col = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(100, 127)) : 7'($urandom);
    it.page = 3'($urandom);
    it.ch = ($urandom_range(0, 9) < 7) ? GLYPH_SET[$urandom_range(0, 38)] : 8'($urandom);
    case ($urandom_range(0, 19))
      0: it.num = 32'h8000_0000;
      1: it.num = 32'h7FFF_FFFF;
      2: it.num = 32'hFFFF_FFFF;
      3: it.num = '0;
      default: it.num = $urandom;
    endcase
    it.cnt = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8)) : 8'($urandom);
    return it;
  endfunction

  // Result sink: random stalls, short and long
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result check against the oldest expected chunk
  always @(posedge clk) begin
    chunk_t got, e;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{page: out_if.out_page, chunk: out_if.chunk, start: out_if.start_column,
              first: out_if.first_of_page, a: out_if.bytes_a, b: out_if.bytes_b,
              c: out_if.bytes_c, d: out_if.bytes_d, last: out_if.last};
      n_chunks++;
      if (chunk_q.size() == 0) begin
        $display("%0t: unexpected chunk %h", $time, got);
        errors++;
      end else begin
        e = chunk_q.pop_front();
        if (got.page !== e.page || got.chunk !== e.chunk || got.start !== e.start ||
            got.first !== e.first || got.a !== e.a || got.b !== e.b ||
            got.c !== e.c || got.d !== e.d || got.last !== e.last) begin
          $display("%0t: chunk mismatch expected %h actual %h", $time, e, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d chunks outstanding", $time, chunk_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  logic [3:0] phase_ofs [4];

  initial begin
    for (int p = 0; p < NPAGE; p++)
      for (int c = 0; c < NCOL; c++) fb[p][c] = '0;
    dirty = '0;
    col_ofs = 4'd2;

    // op, col, page, ch, num, cnt, glance, pages
    dir_rows.push_back('{OP_REFRESH, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b1, 8'h00});
    dir_rows.push_back('{OP_CLEAR, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_REFRESH, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b1, 8'hFF});
    dir_rows.push_back('{OP_REFRESH, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b1, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd0, 3'd0, "0", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd122, 3'd7, "Z", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd123, 3'd6, "A", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd127, 3'd3, 8'hFF, 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd6, 3'd0, 8'h00, 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd12, 3'd0, "a", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd18, 3'd0, "-", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd24, 3'd0, ":", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd30, 3'd0, " ", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_CHAR, 7'd40, 3'd5, "9", 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_REFRESH, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_NUMBER, 7'd0, 3'd1, 8'd0, 32'h8000_0000, 8'd255, 1'b0, 8'h00});
    dir_rows.push_back('{OP_NUMBER, 7'd100, 3'd2, 8'd0, 32'h7FFF_FFFF, 8'd7, 1'b0, 8'h00});
    dir_rows.push_back('{OP_NUMBER, 7'd50, 3'd4, 8'd0, 32'd0, 8'd0, 1'b0, 8'h00});
    dir_rows.push_back('{OP_NUMBER, 7'd60, 3'd4, 8'd0, 32'd12345, 8'd3, 1'b0, 8'h00});
    dir_rows.push_back('{OP_NUMBER, 7'd10, 3'd6, 8'd0, 32'hFFFF_FFFF, 8'd8, 1'b0, 8'h00});
    dir_rows.push_back('{OP_NUMBER, 7'd127, 3'd7, 8'd0, 32'd5, 8'd1, 1'b0, 8'h00});
    dir_rows.push_back('{OP_REFRESH, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'h00});

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    @(negedge clk) in_if.valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own column offset
    phase_ofs = '{4'd0, 4'd15, 4'($urandom), 4'd7};
    for (int ph = 0; ph < 4; ph++) begin
      write_offset(phase_ofs[ph]);
      for (int i = 0; i < 78; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_item(rand_item());
      end
      send_item('{OP_REFRESH, 7'd0, 3'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'h00});
      @(negedge clk) in_if.valid <= 1'b0;
      no_idle = 1'b0;
      wait_drained();
    end

    $display("Covered %0d draw/refresh items and %0d chunk transfers over 5 offset settings",
             n_items, n_chunks);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
